/* rtl/core/bitmap_scaled_blit_writer_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap scaled blit writer core
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SCALED_BLIT_WRITER_CORE_MACROS_SVH
`define BITMAP_SCALED_BLIT_WRITER_CORE_MACROS_SVH

// same-cycle implication
`define BSBW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bsbw_pkg.sv */
// ----------------------------------------------------------------------------
// bsbw_pkg
// Types, constants and register codes of the bitmap scaled blit writer.
// ----------------------------------------------------------------------------
package bsbw_pkg;

    localparam int CounterWidth = 12;
    localparam int DimWidth     = 13;
    localparam int ScaleWidth   = 4;
    localparam int LineWidth    = 15;
    localparam int ColorWidth   = 24;
    localparam int BaseWidth    = 16;
    localparam int PosWidth     = 17;
    localparam int AddrWidth    = 26;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 24;
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 56;
    localparam int QueueDepth   = 4;
    localparam int QueuePtrWidth = $clog2(QueueDepth);

    localparam logic [ScaleWidth-1:0] MaxScale = 4'd8;
    localparam logic [DimWidth-1:0]   MaxDim   = 13'd4096;

    localparam logic [DimWidth-1:0]   RstBitmapWidth  = 13'd8;
    localparam logic [ScaleWidth-1:0] RstScale        = 4'd1;
    localparam logic [DimWidth-1:0]   RstScreenWidth  = 13'd640;
    localparam logic [DimWidth-1:0]   RstScreenHeight = 13'd480;
    localparam logic [LineWidth-1:0]  RstLineBytes    = 15'd1920;
    localparam logic [ColorWidth-1:0] RstDrawColor    = 24'hFFFFFF;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_BITMAP_WIDTH  = 3'd2,
        REG_SCALE         = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_LINE_BYTES    = 3'd6,
        REG_DRAW_COLOR    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [CounterWidth-1:0] origin_x;
        logic [CounterWidth-1:0] origin_y;
        logic [DimWidth-1:0]     bitmap_width;
        logic [ScaleWidth-1:0]   scale;
        logic [DimWidth-1:0]     screen_width;
        logic [DimWidth-1:0]     screen_height;
        logic [LineWidth-1:0]    line_bytes;
        logic [ColorWidth-1:0]   draw_color;
    } cfg_t;

    // one set bit: top-left pixel of the square and its edge length
    typedef struct packed {
        logic [BaseWidth-1:0]  base_x;
        logic [BaseWidth-1:0]  base_y;
        logic [ScaleWidth-1:0] size;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } q_rd_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

endpackage

/* rtl/core/bsbw_front.sv */
// ----------------------------------------------------------------------------
// bsbw_front
// Accepts bitmap bits, tracks source column and row, queues one square
// command per set bit while the scale is nonzero.
// ----------------------------------------------------------------------------
module bsbw_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bsbw_pkg::cfg_t                       cfg,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [bsbw_pkg::InDataWidth-1:0]     s_axis_tdata,  // [0] source_bit
    input  logic                                 s_axis_tlast,  // last_bit
    output bsbw_pkg::q_wr_t                      q_wr,
    input  logic                                 q_full,
    output bsbw_pkg::cmd_t                       q_cmd
);

    logic [bsbw_pkg::CounterWidth-1:0] col_reg, col_next;
    logic [bsbw_pkg::CounterWidth-1:0] row_reg, row_next;
    logic [bsbw_pkg::ScaleWidth-1:0]   s_eff;
    logic [bsbw_pkg::DimWidth-1:0]     w_eff;
    logic [bsbw_pkg::DimWidth-1:0]     col_inc;
    logic [bsbw_pkg::DimWidth-1:0]     sum_x, sum_y;
    logic [bsbw_pkg::PosWidth-1:0]     prod_x, prod_y;
    logic                              accept;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign s_eff = (cfg.scale > bsbw_pkg::MaxScale) ? bsbw_pkg::MaxScale : cfg.scale;

    always_comb
    begin
        if (cfg.bitmap_width == '0)
        begin
            w_eff = bsbw_pkg::DimWidth'(1);
        end
        else if (cfg.bitmap_width > bsbw_pkg::MaxDim)
        begin
            w_eff = bsbw_pkg::MaxDim;
        end
        else
        begin
            w_eff = cfg.bitmap_width;
        end
    end

    assign sum_x  = {1'b0, cfg.origin_x} + {1'b0, col_reg};
    assign sum_y  = {1'b0, cfg.origin_y} + {1'b0, row_reg};
    assign prod_x = bsbw_pkg::PosWidth'(sum_x) * bsbw_pkg::PosWidth'(s_eff);
    assign prod_y = bsbw_pkg::PosWidth'(sum_y) * bsbw_pkg::PosWidth'(s_eff);

    assign q_cmd.base_x = prod_x[bsbw_pkg::BaseWidth-1:0];
    assign q_cmd.base_y = prod_y[bsbw_pkg::BaseWidth-1:0];
    assign q_cmd.size   = s_eff;

    assign q_wr.push = accept && s_axis_tdata[0] && (s_eff != '0);
    assign q_wr.full = q_full;

    assign col_inc = {1'b0, col_reg} + bsbw_pkg::DimWidth'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = row_reg + bsbw_pkg::CounterWidth'(1);
            end
            else
            begin
                col_next = col_inc[bsbw_pkg::CounterWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/core/bsbw_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// bsbw_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module bsbw_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  bsbw_pkg::q_wr_t wr,
    input  bsbw_pkg::cmd_t  wr_cmd,
    input  logic            rd_pop,
    output bsbw_pkg::q_rd_t rd,
    output bsbw_pkg::cmd_t  rd_cmd,
    output logic            full
);

    bsbw_pkg::cmd_t                     mem [bsbw_pkg::QueueDepth];
    logic [bsbw_pkg::QueuePtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bsbw_pkg::QueuePtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bsbw_pkg::QueuePtrWidth:0]   count_reg, count_next;
    logic                               do_push, do_pop;

    assign full     = (count_reg == (bsbw_pkg::QueuePtrWidth+1)'(bsbw_pkg::QueueDepth));
    assign rd.empty = (count_reg == '0);
    assign rd.pop   = do_pop;
    assign rd_cmd   = mem[rd_ptr_reg];

    assign do_push = wr.push && !wr.full;
    assign do_pop  = rd_pop && !rd.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + bsbw_pkg::QueuePtrWidth'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + bsbw_pkg::QueuePtrWidth'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (bsbw_pkg::QueuePtrWidth+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (bsbw_pkg::QueuePtrWidth+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/bsbw_back.sv */
// ----------------------------------------------------------------------------
// bsbw_back
// Walks each clipped square row by row and emits one framebuffer write
// transaction per pixel through a two-stage address pipeline.
// ----------------------------------------------------------------------------
`include "bitmap_scaled_blit_writer_core_macros.svh"

module bsbw_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bsbw_pkg::cfg_t                       cfg,
    input  bsbw_pkg::q_rd_t                      q_rd,
    input  bsbw_pkg::cmd_t                       q_cmd,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [bsbw_pkg::OutDataWidth-1:0]    m_axis_tdata,  // byte_address, blue, green, red
    output logic                                 m_axis_tlast   // last_write
);

    localparam int PosW = bsbw_pkg::PosWidth;

    bsbw_pkg::back_state_t state_reg, state_next;

    logic [PosW-1:0] cur_x_reg, cur_x_next;
    logic [PosW-1:0] cur_y_reg, cur_y_next;
    logic [PosW-1:0] x_first_reg, x_first_next;
    logic [PosW-1:0] x_last_reg, x_last_next;
    logic [PosW-1:0] y_last_reg, y_last_next;

    logic [PosW-1:0] a_x_reg, a_y_reg;
    logic            a_last_reg;
    logic            a_valid_reg, a_valid_next;

    logic [bsbw_pkg::AddrWidth-1:0] m_addr_reg;
    logic                           m_last_reg;
    logic                           m_valid_reg, m_valid_next;

    logic [PosW-1:0] bx, by, x_hi, y_hi, x_lim, y_lim;
    logic            cmd_hits;
    logic            load_cmd;
    logic            gen_emit, gen_last, gen_row_end;
    logic            m_load, a_can_load;
    logic [31:0]     y_term;
    logic [PosW+1:0] x_term;
    logic [32:0]     addr_sum;

    // clip the queued square against the screen
    assign bx       = {1'b0, q_cmd.base_x};
    assign by       = {1'b0, q_cmd.base_y};
    assign x_hi     = bx + {{(PosW-bsbw_pkg::ScaleWidth){1'b0}}, q_cmd.size};
    assign y_hi     = by + {{(PosW-bsbw_pkg::ScaleWidth){1'b0}}, q_cmd.size};
    assign x_lim    = (x_hi > {4'b0, cfg.screen_width})  ? {4'b0, cfg.screen_width}  : x_hi;
    assign y_lim    = (y_hi > {4'b0, cfg.screen_height}) ? {4'b0, cfg.screen_height} : y_hi;
    assign cmd_hits = (bx < {4'b0, cfg.screen_width}) && (by < {4'b0, cfg.screen_height});

    assign m_load     = a_valid_reg && (!m_valid_reg || m_axis_tready);
    assign a_can_load = !a_valid_reg || m_load;

    assign gen_row_end = (cur_x_reg == x_last_reg);
    assign gen_last    = gen_row_end && (cur_y_reg == y_last_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsbw_pkg::BK_IDLE:
            begin
                if (!q_rd.empty && cmd_hits)
                begin
                    state_next = bsbw_pkg::BK_RUN;
                end
            end
            bsbw_pkg::BK_RUN:
            begin
                if (a_can_load && gen_last)
                begin
                    state_next = bsbw_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bsbw_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        load_cmd = 1'b0;
        gen_emit = 1'b0;
        unique case (state_reg)
            bsbw_pkg::BK_IDLE:
            begin
                q_pop    = !q_rd.empty;
                load_cmd = !q_rd.empty && cmd_hits;
            end
            bsbw_pkg::BK_RUN:
            begin
                gen_emit = a_can_load;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        x_first_next = x_first_reg;
        x_last_next  = x_last_reg;
        y_last_next  = y_last_reg;
        if (load_cmd)
        begin
            cur_x_next   = bx;
            cur_y_next   = by;
            x_first_next = bx;
            x_last_next  = x_lim - PosW'(1);
            y_last_next  = y_lim - PosW'(1);
        end
        else if (gen_emit && !gen_last)
        begin
            if (gen_row_end)
            begin
                cur_x_next = x_first_reg;
                cur_y_next = cur_y_reg + PosW'(1);
            end
            else
            begin
                cur_x_next = cur_x_reg + PosW'(1);
            end
        end
    end

    assign a_valid_next = gen_emit ? 1'b1 : (m_load ? 1'b0 : a_valid_reg);
    assign m_valid_next = m_load ? 1'b1 : ((m_valid_reg && m_axis_tready) ? 1'b0 : m_valid_reg);

    assign y_term   = {15'b0, a_y_reg} * {17'b0, cfg.line_bytes};
    assign x_term   = {a_x_reg, 1'b0} + {2'b0, a_x_reg};
    assign addr_sum = {1'b0, y_term} + {14'b0, x_term};

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        x_first_reg <= x_first_next;
        x_last_reg  <= x_last_next;
        y_last_reg  <= y_last_next;
        if (gen_emit)
        begin
            a_x_reg    <= cur_x_reg;
            a_y_reg    <= cur_y_reg;
            a_last_reg <= gen_last;
        end
        if (m_load)
        begin
            m_addr_reg <= addr_sum[bsbw_pkg::AddrWidth-1:0];
            m_last_reg <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bsbw_pkg::BK_IDLE;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {6'b0, cfg.draw_color[23:16], cfg.draw_color[15:8],
                            cfg.draw_color[7:0], m_addr_reg};

    `BSBW_ASSERT_IMPLIES(a_walk_in_square, clk, rst_n,
        state_reg == bsbw_pkg::BK_RUN,
        (cur_x_reg <= x_last_reg) && (cur_y_reg <= y_last_reg),
        "walk position left the square")
    `BSBW_ASSERT_IMPLIES(a_run_ends_on_last, clk, rst_n,
        (state_reg == bsbw_pkg::BK_RUN) && (state_next == bsbw_pkg::BK_IDLE),
        gen_emit && gen_last,
        "square ended without its last pixel")
    `BSBW_ASSERT_NEXT(a_last_returns_idle, clk, rst_n,
        gen_emit && gen_last,
        (state_reg == bsbw_pkg::BK_IDLE) && a_valid_reg && a_last_reg,
        "last pixel did not close the square")

endmodule

/* rtl/core/bitmap_scaled_blit_writer_core.sv */
// ----------------------------------------------------------------------------
// bitmap_scaled_blit_writer_core
// Expands 1bpp bitmap bits into scaled, clipped framebuffer write transactions.
// ----------------------------------------------------------------------------
// Throughput: one write per cycle inside a square while m_axis_tready holds; a square
// is fetched from the 4-entry queue, then walked pixel by pixel. Clear bits and bits
// at scale zero queue nothing, fully clipped squares are dropped at the fetch; input
// stalls only on a full queue.
// Reset: counters zero, queue and pipeline empty, registers at their defaults.
// ----------------------------------------------------------------------------
module bitmap_scaled_blit_writer_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bsbw_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [bsbw_pkg::CfgDataWidth-1:0]    cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [bsbw_pkg::InDataWidth-1:0]     s_axis_tdata,  // [0] source_bit
    input  logic                                 s_axis_tlast,  // last_bit
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [bsbw_pkg::OutDataWidth-1:0]    m_axis_tdata,  // [25:0] byte_address,
                                                                // [33:26] blue, [41:34] green,
                                                                // [49:42] red
    output logic                                 m_axis_tlast   // last_write
);

    bsbw_pkg::cfg_t  cfg_reg, cfg_next;
    bsbw_pkg::q_wr_t q_wr;
    bsbw_pkg::q_rd_t q_rd;
    bsbw_pkg::cmd_t  wr_cmd, rd_cmd;
    logic            q_full;
    logic            q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bsbw_pkg::REG_ORIGIN_X:      cfg_next.origin_x      = cfg_data[11:0];
                bsbw_pkg::REG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data[11:0];
                bsbw_pkg::REG_BITMAP_WIDTH:  cfg_next.bitmap_width  = cfg_data[12:0];
                bsbw_pkg::REG_SCALE:         cfg_next.scale         = cfg_data[3:0];
                bsbw_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[12:0];
                bsbw_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[12:0];
                bsbw_pkg::REG_LINE_BYTES:    cfg_next.line_bytes    = cfg_data[14:0];
                bsbw_pkg::REG_DRAW_COLOR:    cfg_next.draw_color    = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.bitmap_width  <= bsbw_pkg::RstBitmapWidth;
            cfg_reg.scale         <= bsbw_pkg::RstScale;
            cfg_reg.screen_width  <= bsbw_pkg::RstScreenWidth;
            cfg_reg.screen_height <= bsbw_pkg::RstScreenHeight;
            cfg_reg.line_bytes    <= bsbw_pkg::RstLineBytes;
            cfg_reg.draw_color    <= bsbw_pkg::RstDrawColor;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bsbw_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_wr          (q_wr),
        .q_full        (q_full),
        .q_cmd         (wr_cmd)
    );

    bsbw_cmd_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_cmd (wr_cmd),
        .rd_pop (q_pop),
        .rd     (q_rd),
        .rd_cmd (rd_cmd),
        .full   (q_full)
    );

    bsbw_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_rd          (q_rd),
        .q_cmd         (rd_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* tb/tb_bitmap_scaled_blit_writer_core.sv */
// ----------------------------------------------------------------------------
// Testbench for bitmap_scaled_blit_writer_core
// Streams bitmap bits into the core and checks every framebuffer write
// transaction against a cycle-free model of the scaled, clipped blit. Runs
// directed corner cases, then random bitmaps under several idling mixes,
// a long receiver hold-off, and an oversized bitmap width.
// ----------------------------------------------------------------------------
module tb_bitmap_scaled_blit_writer_core;

    localparam int SettleCycles = 24;

    typedef struct packed {
        logic [bsbw_pkg::AddrWidth-1:0] byte_address;
        logic [7:0]                     blue;
        logic [7:0]                     green;
        logic [7:0]                     red;
        logic                           last_write;
    } pixel_write_t;

    class blit_write_board;
        logic [bsbw_pkg::CounterWidth-1:0] origin_x;
        logic [bsbw_pkg::CounterWidth-1:0] origin_y;
        logic [bsbw_pkg::DimWidth-1:0]     bitmap_width;
        logic [bsbw_pkg::ScaleWidth-1:0]   scale;
        logic [bsbw_pkg::DimWidth-1:0]     screen_width;
        logic [bsbw_pkg::DimWidth-1:0]     screen_height;
        logic [bsbw_pkg::LineWidth-1:0]    line_bytes;
        logic [bsbw_pkg::ColorWidth-1:0]   draw_color;
        logic [bsbw_pkg::CounterWidth-1:0] column;
        logic [bsbw_pkg::CounterWidth-1:0] row;
        pixel_write_t                      pending_writes[$];
        int                                errors;
        int                                writes_seen;
        int                                bits_seen;
        int                                reg_writes;

        function new();
            origin_x      = '0;
            origin_y      = '0;
            bitmap_width  = bsbw_pkg::RstBitmapWidth;
            scale         = bsbw_pkg::RstScale;
            screen_width  = bsbw_pkg::RstScreenWidth;
            screen_height = bsbw_pkg::RstScreenHeight;
            line_bytes    = bsbw_pkg::RstLineBytes;
            draw_color    = bsbw_pkg::RstDrawColor;
            column        = '0;
            row           = '0;
            errors        = 0;
            writes_seen   = 0;
            bits_seen     = 0;
            reg_writes    = 0;
        endfunction

        function void write_reg(bsbw_pkg::cfg_reg_t idx,
                                logic [bsbw_pkg::CfgDataWidth-1:0] value);
            reg_writes++;
            case (idx)
                bsbw_pkg::REG_ORIGIN_X:      origin_x      = value[bsbw_pkg::CounterWidth-1:0];
                bsbw_pkg::REG_ORIGIN_Y:      origin_y      = value[bsbw_pkg::CounterWidth-1:0];
                bsbw_pkg::REG_BITMAP_WIDTH:  bitmap_width  = value[bsbw_pkg::DimWidth-1:0];
                bsbw_pkg::REG_SCALE:         scale         = value[bsbw_pkg::ScaleWidth-1:0];
                bsbw_pkg::REG_SCREEN_WIDTH:  screen_width  = value[bsbw_pkg::DimWidth-1:0];
                bsbw_pkg::REG_SCREEN_HEIGHT: screen_height = value[bsbw_pkg::DimWidth-1:0];
                bsbw_pkg::REG_LINE_BYTES:    line_bytes    = value[bsbw_pkg::LineWidth-1:0];
                bsbw_pkg::REG_DRAW_COLOR:    draw_color    = value[bsbw_pkg::ColorWidth-1:0];
                default: ;
            endcase
        endfunction

        // expand one accepted bit into its visible pixel writes, then step the counters
        function void note_bit(logic src, logic last);
            int unsigned  side;
            int unsigned  base_x;
            int unsigned  base_y;
            int unsigned  x;
            int unsigned  y;
            int unsigned  vis_rows;
            int unsigned  vis_cols;
            int unsigned  total;
            int unsigned  n;
            int unsigned  span;
            logic [63:0]  addr;
            pixel_write_t w;
            bits_seen++;
            if (src)
            begin
                side     = (scale > bsbw_pkg::MaxScale) ? 32'(bsbw_pkg::MaxScale) : 32'(scale);
                base_x   = (32'(origin_x) + 32'(column)) * side;
                base_y   = (32'(origin_y) + 32'(row)) * side;
                vis_rows = 0;
                vis_cols = 0;
                for (int unsigned i = 0; i < side; i++)
                begin
                    if (base_y + i < screen_height) vis_rows++;
                    if (base_x + i < screen_width) vis_cols++;
                end
                total = vis_rows * vis_cols;
                n     = 0;
                for (int unsigned i = 0; i < side; i++)
                begin
                    y = base_y + i;
                    if (y < screen_height)
                    begin
                        for (int unsigned j = 0; j < side; j++)
                        begin
                            x = base_x + j;
                            if (x < screen_width)
                            begin
                                addr           = 64'(y) * 64'(line_bytes) + 64'(x) * 64'd3;
                                w.byte_address = addr[bsbw_pkg::AddrWidth-1:0];
                                w.blue         = draw_color[7:0];
                                w.green        = draw_color[15:8];
                                w.red          = draw_color[23:16];
                                w.last_write   = (n == total - 1);
                                pending_writes.push_back(w);
                                n++;
                            end
                        end
                    end
                end
            end
            if (last)
            begin
                column = '0;
                row    = '0;
            end
            else
            begin
                span = (bitmap_width == 0) ? 1 : 32'(bitmap_width);
                if (span > bsbw_pkg::MaxDim) span = 32'(bsbw_pkg::MaxDim);
                if (32'(column) + 1 >= span)
                begin
                    column = '0;
                    row    = row + bsbw_pkg::CounterWidth'(1);
                end
                else
                    column = column + bsbw_pkg::CounterWidth'(1);
            end
        endfunction

        function void compare_field(string field, longint unsigned want_v,
                                    longint unsigned got_v);
            if (want_v != got_v)
            begin
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, field, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_write(logic [bsbw_pkg::OutDataWidth-1:0] data, logic lastw);
            pixel_write_t want;
            writes_seen++;
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write, expected none, actual address 0x%0h",
                         $time, data[25:0]);
                errors++;
                return;
            end
            want = pending_writes.pop_front();
            compare_field("byte_address", want.byte_address, data[25:0]);
            compare_field("blue", want.blue, data[33:26]);
            compare_field("green", want.green, data[41:34]);
            compare_field("red", want.red, data[49:42]);
            compare_field("last_write", want.last_write, lastw);
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [bsbw_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
    logic [bsbw_pkg::CfgDataWidth-1:0] cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [bsbw_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
    logic                              s_axis_tlast = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [bsbw_pkg::OutDataWidth-1:0] m_axis_tdata;
    logic                              m_axis_tlast;

    blit_write_board board;
    int              sender_idle_pct = 0;
    int              stall_pct = 0;
    int              hold_off_cycles = 0;

    bitmap_scaled_blit_writer_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #24000000;
        $display("tb: failure");
        $finish;
    end

    // input transaction is noted before the write transaction of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready) board.note_bit(s_axis_tdata[0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) board.check_write(m_axis_tdata, m_axis_tlast);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_bit(input logic src, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(bsbw_pkg::InDataWidth-1){1'b0}}, src};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic stop_bits();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_writes();
        do @(negedge clk); while (board.pending_writes.size() != 0);
    endtask

    // clipped or clear bits may still be in flight after the last write
    task automatic drain_and_settle();
        stop_bits();
        wait_for_writes();
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(input bsbw_pkg::cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= bsbw_pkg::CfgDataWidth'(value);
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, bsbw_pkg::CfgDataWidth'(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic setup_screen(input int unsigned width, input int unsigned scl,
                                input int unsigned sw, input int unsigned sh,
                                input int unsigned lb);
        write_reg(bsbw_pkg::REG_ORIGIN_X, 0);
        write_reg(bsbw_pkg::REG_ORIGIN_Y, 0);
        write_reg(bsbw_pkg::REG_BITMAP_WIDTH, width);
        write_reg(bsbw_pkg::REG_SCALE, scl);
        write_reg(bsbw_pkg::REG_SCREEN_WIDTH, sw);
        write_reg(bsbw_pkg::REG_SCREEN_HEIGHT, sh);
        write_reg(bsbw_pkg::REG_LINE_BYTES, lb);
        write_reg(bsbw_pkg::REG_DRAW_COLOR, $urandom_range(24'hFFFFFF));
    endtask

    task automatic setup_random(input int unsigned width);
        write_reg(bsbw_pkg::REG_ORIGIN_X, $urandom_range(40));
        write_reg(bsbw_pkg::REG_ORIGIN_Y, $urandom_range(40));
        write_reg(bsbw_pkg::REG_BITMAP_WIDTH, width);
        if ($urandom_range(9) == 0)
            write_reg(bsbw_pkg::REG_SCALE, $urandom_range(15));
        else
            write_reg(bsbw_pkg::REG_SCALE, $urandom_range(8, 1));
        if ($urandom_range(3) == 0)
            write_reg(bsbw_pkg::REG_SCREEN_WIDTH, $urandom_range(200, 16));
        else
            write_reg(bsbw_pkg::REG_SCREEN_WIDTH, $urandom_range(4096, 200));
        if ($urandom_range(3) == 0)
            write_reg(bsbw_pkg::REG_SCREEN_HEIGHT, $urandom_range(200, 16));
        else
            write_reg(bsbw_pkg::REG_SCREEN_HEIGHT, $urandom_range(4096, 200));
        write_reg(bsbw_pkg::REG_LINE_BYTES, $urandom_range(16384, 3));
        write_reg(bsbw_pkg::REG_DRAW_COLOR, $urandom_range(24'hFFFFFF));
    endtask

    // mostly whole bitmaps closed by a last bit, some stray bits in between
    task automatic run_bitmap_phase(input int send_pct, input int recv_pct,
                                    input int target, input bit pause_midway);
        int unsigned width;
        int unsigned span;
        int unsigned run_len;
        int          sent;
        bit          paused;
        width  = $urandom_range(6);
        span   = (width == 0) ? 1 : width;
        sent   = 0;
        paused = 1'b0;
        setup_random(width);
        sender_idle_pct = send_pct;
        stall_pct       = recv_pct;
        while (sent < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_bit(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                run_len = span * $urandom_range(4, 1);
                for (int unsigned k = 0; k < run_len; k++)
                begin
                    send_bit(1'($urandom_range(1)), k == run_len - 1);
                    sent++;
                end
            end
            if (pause_midway && !paused && sent >= target / 2)
            begin
                paused = 1'b1;
                stop_bits();
                wait_for_writes();
            end
        end
        drain_and_settle();
        sender_idle_pct = 0;
        stall_pct       = 0;
    endtask

    initial
    begin
        board = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults straight out of reset
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b1, 1'b0);
        drain_and_settle();

        // saturated scale, zero bitmap width, address wrap
        write_reg(bsbw_pkg::REG_ORIGIN_X, 1000);
        write_reg(bsbw_pkg::REG_ORIGIN_Y, 1000);
        write_reg(bsbw_pkg::REG_BITMAP_WIDTH, 0);
        write_reg(bsbw_pkg::REG_SCALE, 15);
        write_reg(bsbw_pkg::REG_SCREEN_WIDTH, 8191);
        write_reg(bsbw_pkg::REG_SCREEN_HEIGHT, 8191);
        write_reg(bsbw_pkg::REG_LINE_BYTES, 32767);
        write_reg(bsbw_pkg::REG_DRAW_COLOR, 0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        drain_and_settle();

        write_reg(bsbw_pkg::REG_SCALE, 0);
        write_reg(bsbw_pkg::REG_DRAW_COLOR, 24'hFFFFFF);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        drain_and_settle();

        // whole square off screen, then partly off screen
        write_reg(bsbw_pkg::REG_SCALE, 8);
        write_reg(bsbw_pkg::REG_ORIGIN_X, 4095);
        send_bit(1'b1, 1'b1);
        drain_and_settle();
        write_reg(bsbw_pkg::REG_ORIGIN_X, 1023);
        write_reg(bsbw_pkg::REG_SCREEN_WIDTH, 8190);
        write_reg(bsbw_pkg::REG_SCREEN_HEIGHT, 0);
        send_bit(1'b1, 1'b0);
        drain_and_settle();
        write_reg(bsbw_pkg::REG_SCREEN_HEIGHT, 8191);
        write_reg(bsbw_pkg::REG_DRAW_COLOR, 24'h5AC3A5);
        send_bit(1'b1, 1'b1);
        drain_and_settle();

        // zero line stride, zero and one pixel wide screens
        write_reg(bsbw_pkg::REG_ORIGIN_X, 0);
        write_reg(bsbw_pkg::REG_ORIGIN_Y, 4095);
        write_reg(bsbw_pkg::REG_SCALE, 1);
        write_reg(bsbw_pkg::REG_LINE_BYTES, 0);
        write_reg(bsbw_pkg::REG_SCREEN_WIDTH, 0);
        send_bit(1'b1, 1'b0);
        drain_and_settle();
        write_reg(bsbw_pkg::REG_SCREEN_WIDTH, 1);
        write_reg(bsbw_pkg::REG_BITMAP_WIDTH, 8191);
        write_reg(bsbw_pkg::REG_LINE_BYTES, 3);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        drain_and_settle();

        run_bitmap_phase(0, 0, 100, 1'b0);
        run_bitmap_phase(47, 0, 100, 1'b1);
        run_bitmap_phase(0, 47, 100, 1'b0);
        run_bitmap_phase(14, 14, 100, 1'b0);

        // long receiver hold-off while the sender keeps offering squares
        setup_screen(8, 4, 4096, 4096, 16384);
        hold_off_cycles = 300;
        for (int k = 0; k < 24; k++) send_bit(1'b1, k == 23);
        drain_and_settle();

        // oversized bitmap width, columns keep counting
        setup_screen(8191, 1, 4096, 4096, 16384);
        stall_pct = 14;
        for (int k = 0; k < 20; k++)
            send_bit(1'($urandom_range(1)), k == 19);
        drain_and_settle();

        $display("summary: %0d bitmap bits and %0d register writes, %0d pixel writes checked",
                 board.bits_seen, board.reg_writes, board.writes_seen);
        $display("summary: directed corners, four idling mixes, hold-off, oversized width");
        if (board.errors == 0 && board.pending_writes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
